### rtl/core/rfbp_pkg.sv
package rfbp_pkg;

  // Fixed field widths of the request and result beats
  localparam int DATA_W = 32;
  localparam int LEN_W  = 7;
  localparam int IDX_W  = 10;

  // Request kinds
  typedef logic [1:0] op_t;
  localparam op_t OP_PUSH  = 2'd0;
  localparam op_t OP_POP   = 2'd1;
  localparam op_t OP_TPOP  = 2'd2;
  localparam op_t OP_FLUSH = 2'd3;

  // Request queue between front and back (power of two)
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  // Classified request as it travels from front to back
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  min_len;
    logic [LEN_W-1:0]  max_len;  // already limited to the burst size
  } req_t;

endpackage

### rtl/core/ring_fifo_burst_pop.sv
// Channel   Handshake            Beat contents
// in        in_valid / in_ready  req_type, push_data, min_len, max_len
// out       out_valid/out_ready  out_data, data_valid, last_of_run, push_accepted,
//                                fill_level, write_index, read_index
//
// Push, flush and empty pops give one result beat each,
// so one request per cycle while the output drains.
// A pop of n elements first starts the store read, then gives one element per
// cycle while the output is not stalled, set by the store's registered read port.
// A two-entry request queue lets requests arrive while a run is draining.
// rst is synchronous; it empties the FIFO and the queue; store contents stay.
// A stalled output holds its beat; the run resumes when out_ready returns.
module ring_fifo_burst_pop import rfbp_pkg::*; #(
  parameter int DEPTH         = 1024,
  parameter int ELEMENT_WIDTH = 32,
  parameter int MAX_BURST     = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [DATA_W-1:0] push_data,
  input  logic [LEN_W-1:0]  min_len,
  input  logic [LEN_W-1:0]  max_len,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic              data_valid,
  output logic              last_of_run,
  output logic              push_accepted,
  output logic [IDX_W-1:0]  fill_level,
  output logic [IDX_W-1:0]  write_index,
  output logic [IDX_W-1:0]  read_index
);

  logic q_valid;
  logic q_ready;
  req_t q_req;

  rfbp_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .push_data (push_data),
    .min_len   (min_len),
    .max_len   (max_len),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req)
  );

  rfbp_back #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_req         (q_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .data_valid    (data_valid),
    .last_of_run   (last_of_run),
    .push_accepted (push_accepted),
    .fill_level    (fill_level),
    .write_index   (write_index),
    .read_index    (read_index)
  );

endmodule

### rtl/core/rfbp_ram.sv
module rfbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; rdata holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/rfbp_front.sv
module rfbp_front import rfbp_pkg::*; #(
  parameter int MAX_BURST = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [DATA_W-1:0] push_data,
  input  logic [LEN_W-1:0]  min_len,
  input  logic [LEN_W-1:0]  max_len,
  output logic              q_valid,
  input  logic              q_ready,
  output req_t              q_req
);

  localparam logic [LEN_W-1:0] BURST_LIM = LEN_W'(MAX_BURST);

  req_t             entries [QDEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QPW:0]     cnt;
  logic             push;
  logic             pop;
  req_t             req_in;

  // Classify the incoming beat and saturate the run length
  always_comb begin
    req_in.op      = op_t'(req_type);
    req_in.data    = push_data;
    req_in.min_len = min_len;
    req_in.max_len = (max_len > BURST_LIM) ? BURST_LIM : max_len;
  end

  assign in_ready = (cnt != (QPW+1)'(QDEPTH));
  assign q_valid  = (cnt != '0);
  assign q_req    = entries[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req_in;
    end
  end

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QPW+1)'(QDEPTH))
    else $error("request queue over capacity");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with mismatched pointers");

endmodule

### rtl/core/rfbp_back.sv
module rfbp_back import rfbp_pkg::*; #(
  parameter int DEPTH         = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  req_t              q_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic              data_valid,
  output logic              last_of_run,
  output logic              push_accepted,
  output logic [IDX_W-1:0]  fill_level,
  output logic [IDX_W-1:0]  write_index,
  output logic [IDX_W-1:0]  read_index
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_POP  = 1'b1;

  logic                     state;
  logic                     state_next;
  logic [PW-1:0]            wp;
  logic [PW-1:0]            wp_next;
  logic [PW-1:0]            rp;
  logic [PW-1:0]            rp_next;
  logic [LEN_W-1:0]         count;
  logic [LEN_W-1:0]         count_next;

  logic [PW:0]              diff;
  logic [PW-1:0]            fill;
  logic                     full;
  logic [PW-1:0]            wp_inc;
  logic [PW-1:0]            rp_inc;
  logic [LEN_W-1:0]         run_len;
  logic                     thr_miss;
  logic                     out_free;

  logic                     we;
  logic                     re;
  logic [PW-1:0]            raddr;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [ELEMENT_WIDTH-1:0] rdata;

  logic                     load;
  logic [DATA_W-1:0]        ld_data;
  logic                     ld_dv;
  logic                     ld_last;
  logic                     ld_acc;
  logic [PW-1:0]            ld_fill;

  rfbp_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Fill level, full flag and pointer increments
  always_comb begin
    diff = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      diff = diff + (PW+1)'(DEPTH);
    end
    fill   = diff[PW-1:0];
    full   = (fill == LAST_SLOT);
    wp_inc = (wp == LAST_SLOT) ? '0 : wp + 1'b1;
    rp_inc = (rp == LAST_SLOT) ? '0 : rp + 1'b1;
  end

  // Run length and threshold check for pop requests
  assign run_len  = (32'(fill) < 32'(q_req.max_len)) ? LEN_W'(fill) : q_req.max_len;
  assign thr_miss = (q_req.op == OP_TPOP) &&
                    ((fill == '0) || (32'(fill) < 32'(q_req.min_len)));
  assign wdata    = ELEMENT_WIDTH'(64'(q_req.data));
  assign out_free = !out_valid || out_ready;

  // Request execution
  always_comb begin
    state_next = state;
    wp_next    = wp;
    rp_next    = rp;
    count_next = count;
    q_ready    = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    raddr      = rp;
    load       = 1'b0;
    ld_data    = '0;
    ld_dv      = 1'b0;
    ld_last    = 1'b1;
    ld_acc     = 1'b0;
    ld_fill    = fill;
    case (state)
      STATE_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          case (q_req.op)
            OP_PUSH: begin
              load = 1'b1;
              if (!full) begin
                we      = 1'b1;
                wp_next = wp_inc;
                ld_acc  = 1'b1;
                ld_fill = fill + 1'b1;
              end
            end
            OP_FLUSH: begin
              load    = 1'b1;
              rp_next = wp;
              ld_fill = '0;
            end
            OP_POP, OP_TPOP: begin
              if (thr_miss || (run_len == '0)) begin
                load = 1'b1;
              end else begin
                re         = 1'b1;
                raddr      = rp;
                count_next = run_len;
                state_next = STATE_POP;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      STATE_POP: begin
        // rdata holds the element at rp; send it and, unless it is the last, fetch the next one
        if (out_free) begin
          load       = 1'b1;
          ld_data    = DATA_W'(64'(rdata));
          ld_dv      = 1'b1;
          ld_last    = (count == LEN_W'(1));
          ld_fill    = fill - 1'b1;
          rp_next    = rp_inc;
          count_next = count - 1'b1;
          if (ld_last) begin
            state_next = STATE_IDLE;
          end else begin
            re    = 1'b1;
            raddr = rp_inc;
          end
        end
      end
      default: begin
        state_next = STATE_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_IDLE;
      wp        <= '0;
      rp        <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      rp    <= rp_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data      <= ld_data;
      data_valid    <= ld_dv;
      last_of_run   <= ld_last;
      push_accepted <= ld_acc;
      fill_level    <= IDX_W'(32'(ld_fill));
      write_index   <= IDX_W'(32'(wp_next));
      read_index    <= IDX_W'(32'(rp_next));
    end
  end

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (state == STATE_POP) |-> (count != '0))
    else $error("pop run active with zero count");

  a_no_write_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == STATE_POP) |-> !we)
    else $error("store written during a pop run");

  a_data_not_push: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_valid) |-> !push_accepted)
    else $error("data beat flagged as accepted push");

  a_run_fill: assert property (@(posedge clk) disable iff (rst)
    (state == STATE_POP) |-> (32'(fill) >= 32'(count)))
    else $error("pop run longer than fill level");

endmodule

### bench/ring_fifo_burst_pop_checker.sv
module ring_fifo_burst_pop_checker import rfbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [DATA_W-1:0] push_data,
  input  logic [LEN_W-1:0]  min_len,
  input  logic [LEN_W-1:0]  max_len,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] out_data,
  input  logic              data_valid,
  input  logic              last_of_run,
  input  logic              push_accepted,
  input  logic [IDX_W-1:0]  fill_level,
  input  logic [IDX_W-1:0]  write_index,
  input  logic [IDX_W-1:0]  read_index,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS = 1024;
  localparam int BURST_CAP  = 64;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              dv;
    logic              last;
    logic              acc;
    logic [IDX_W-1:0]  fill;
    logic [IDX_W-1:0]  wr;
    logic [IDX_W-1:0]  rd;
  } result_beat_t;

  // Shadow copy of the ring and its pointers
  logic [DATA_W-1:0] ring_mem [RING_SLOTS];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  result_beat_t      awaited_beats[$];

  // Pointers wrap at 1024, so the 10-bit difference is the fill
  function automatic int held_count();
    logic [IDX_W-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return int'(diff);
  endfunction

  // Every beat reports the pointers as they stand after it
  task automatic queue_beat(input logic [DATA_W-1:0] d, input logic dv, input logic last,
                            input logic acc);
    result_beat_t b;
    b.data = d;
    b.dv   = dv;
    b.last = last;
    b.acc  = acc;
    b.fill = wr_ptr - rd_ptr;
    b.wr   = wr_ptr;
    b.rd   = rd_ptr;
    awaited_beats.push_back(b);
  endtask

  // Run of min(fill, limit, burst cap) elements; an empty run is one bare beat
  task automatic drain_burst(input logic [LEN_W-1:0] limit);
    int n;
    logic [DATA_W-1:0] word;
    n = held_count();
    if (int'(limit) < n) n = int'(limit);
    if (n > BURST_CAP) n = BURST_CAP;
    if (n == 0) queue_beat('0, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < n; i++) begin
      word   = ring_mem[rd_ptr];
      rd_ptr = rd_ptr + 1'b1;
      queue_beat(word, 1'b1, i == n - 1, 1'b0);
    end
  endtask

  task automatic apply_request(input op_t op, input logic [DATA_W-1:0] d,
                               input logic [LEN_W-1:0] floor_len,
                               input logic [LEN_W-1:0] limit);
    int level;
    level = held_count();
    case (op)
      OP_PUSH: begin
        // one slot always stays free; a push into a full ring is dropped
        if (level < RING_SLOTS - 1) begin
          ring_mem[wr_ptr] = d;
          wr_ptr = wr_ptr + 1'b1;
          queue_beat('0, 1'b0, 1'b1, 1'b1);
        end else begin
          queue_beat('0, 1'b0, 1'b1, 1'b0);
        end
      end
      OP_POP: drain_burst(limit);
      OP_TPOP: begin
        if (level == 0 || level < int'(floor_len)) queue_beat('0, 1'b0, 1'b1, 1'b0);
        else drain_burst(limit);
      end
      OP_FLUSH: begin
        rd_ptr = wr_ptr;
        queue_beat('0, 1'b0, 1'b1, 1'b0);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on request beats, compare on result beats
  always @(posedge clk) begin
    result_beat_t want;
    if (rst) begin
      wr_ptr = '0;
      rd_ptr = '0;
      awaited_beats.delete();
    end else begin
      if (in_valid && in_ready) apply_request(op_t'(req_type), push_data, min_len, max_len);
      if (out_valid && out_ready) begin
        if (awaited_beats.size() == 0) begin
          $error("result beat with none expected, out_data %0h", out_data);
          mismatches++;
        end else begin
          want = awaited_beats.pop_front();
          check_field("out_data", want.data, out_data);
          check_field("data_valid", DATA_W'(want.dv), DATA_W'(data_valid));
          check_field("last_of_run", DATA_W'(want.last), DATA_W'(last_of_run));
          check_field("push_accepted", DATA_W'(want.acc), DATA_W'(push_accepted));
          check_field("fill_level", DATA_W'(want.fill), DATA_W'(fill_level));
          check_field("write_index", DATA_W'(want.wr), DATA_W'(write_index));
          check_field("read_index", DATA_W'(want.rd), DATA_W'(read_index));
        end
      end
    end
    outstanding = awaited_beats.size();
  end

endmodule

### bench/ring_fifo_burst_pop_tb.sv
module ring_fifo_burst_pop_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 500;
  localparam int RANDOM_ITEMS   = 50;
  localparam int SETTLE_CYCLES  = 20;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [1:0]        req_type  = OP_PUSH;
  logic [DATA_W-1:0] push_data = '0;
  logic [LEN_W-1:0]  min_len   = '0;
  logic [LEN_W-1:0]  max_len   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_data;
  logic              data_valid;
  logic              last_of_run;
  logic              push_accepted;
  logic [IDX_W-1:0]  fill_level;
  logic [IDX_W-1:0]  write_index;
  logic [IDX_W-1:0]  read_index;
  int                mismatches;
  int                outstanding;

  bit hold_request = 1'b0;
  int tx_calm      = 0;
  int idle_cycles  = 0;

  ring_fifo_burst_pop dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .push_data(push_data), .min_len(min_len), .max_len(max_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .data_valid(data_valid), .last_of_run(last_of_run),
    .push_accepted(push_accepted), .fill_level(fill_level),
    .write_index(write_index), .read_index(read_index)
  );

  ring_fifo_burst_pop_checker fifo_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .push_data(push_data), .min_len(min_len), .max_len(max_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .data_valid(data_valid), .last_of_run(last_of_run),
    .push_accepted(push_accepted), .fill_level(fill_level),
    .write_index(write_index), .read_index(read_index),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long with no beat on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result sink: random stalls, calm stretches, and one long hold on request
  initial begin
    int gap;
    int calm;
    calm = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end else if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 24) == 0) calm = 40;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // One request beat, after a random gap unless in a calm stretch
  task automatic send_req(input op_t op, input logic [DATA_W-1:0] d,
                          input logic [LEN_W-1:0] floor_len,
                          input logic [LEN_W-1:0] limit);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 24) == 0) tx_calm = 40;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type  <= op;
    push_data <= d;
    min_len   <= floor_len;
    max_len   <= limit;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // Mostly short lengths, sometimes any length up to the cap, sometimes the cap
  function automatic logic [LEN_W-1:0] rand_len();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return LEN_W'($urandom_range(0, 16));
    if (pick < 9) return LEN_W'($urandom_range(0, 64));
    return LEN_W'(64);
  endfunction

  initial begin
    int done;
    int kind;
    int run;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pops, data extremes, zero length, thresholds, flush
    send_req(OP_POP, rand_word(), 7'd0, 7'd64);
    send_req(OP_TPOP, rand_word(), 7'd0, 7'd64);
    send_req(OP_PUSH, 32'h0000_0000, 7'd64, 7'd64);
    send_req(OP_PUSH, 32'hFFFF_FFFF, 7'd0, 7'd0);
    send_req(OP_PUSH, 32'hA5A5_A5A5, 7'd1, 7'd1);
    send_req(OP_POP, rand_word(), 7'd0, 7'd0);
    send_req(OP_TPOP, rand_word(), 7'd4, 7'd64);
    send_req(OP_TPOP, rand_word(), 7'd3, 7'd2);
    send_req(OP_POP, rand_word(), 7'd0, 7'd64);
    repeat (3) send_req(OP_PUSH, rand_word(), rand_len(), rand_len());
    send_req(OP_FLUSH, rand_word(), 7'd0, 7'd0);
    send_req(OP_POP, rand_word(), 7'd0, 7'd1);
    send_req(OP_PUSH, 32'h5A5A_5A5A, 7'd0, 7'd0);
    send_req(OP_PUSH, 32'h1234_5678, 7'd0, 7'd0);
    send_req(OP_TPOP, rand_word(), 7'd64, 7'd64);
    send_req(OP_POP, rand_word(), 7'd0, 7'd64);
    send_req(OP_FLUSH, rand_word(), 7'd64, 7'd64);

    // Short fills, pops of assorted lengths, threshold misses, flush
    for (int i = 0; i < 12; i++) send_req(OP_PUSH, rand_word(), 7'd0, 7'd0);
    send_req(OP_TPOP, rand_word(), 7'd64, 7'd64);
    send_req(OP_POP, rand_word(), 7'd0, 7'd63);
    for (int i = 0; i < 12; i++) send_req(OP_PUSH, rand_word(), 7'd0, 7'd0);
    for (int i = 0; i < 12; i++) send_req(OP_POP, rand_word(), 7'd0, rand_len());
    send_req(OP_TPOP, rand_word(), 7'd64, 7'd64);
    send_req(OP_FLUSH, rand_word(), 7'd0, 7'd0);

    // Back-pressure: the sink holds off while pushes keep coming
    hold_request = 1'b1;
    tx_calm = 60;
    for (int i = 0; i < 40; i++) send_req(OP_PUSH, rand_word(), 7'd0, 7'd0);
    send_req(OP_POP, rand_word(), 7'd0, 7'd64);

    // Random mix: push runs, pops, threshold pops, rare flushes
    done = 0;
    while (done < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        run = $urandom_range(1, 12);
        repeat (run) send_req(OP_PUSH, rand_word(), rand_len(), rand_len());
        done += run;
      end else if (kind < 6) begin
        send_req(OP_POP, rand_word(), rand_len(), rand_len());
        done++;
      end else if (kind < 9) begin
        send_req(OP_TPOP, rand_word(), rand_len(), rand_len());
        done++;
      end else begin
        if ($urandom_range(0, 1) == 0) send_req(OP_FLUSH, rand_word(), rand_len(), rand_len());
        else send_req(OP_POP, rand_word(), 7'd0, 7'd0);
        done++;
      end
    end
    in_valid <= 1'b0;

    // Drain, settle, verdict
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (outstanding != 0) $error("%0d result beats never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
